/* hdl/mbm_pkg.sv */
`timescale 1ns / 1ps
// mbm_pkg: shared types, constants and box geometry helpers for the
// motion box merge / square crop block. No dependencies.
package mbm_pkg;

  localparam int unsigned SLACK    = 16;
  localparam int unsigned DEF_SIDE = 320;
  localparam int unsigned MAX_CAP  = 32;
  localparam int unsigned FRAME_MAX = 4096;
  // floor(t / 5) == (t * RECIP5) >> 18 for t below 81920
  localparam logic [15:0] RECIP5 = 16'd52429;

  typedef enum logic [1:0] {
    REG_FRAME_W = 2'd0,
    REG_FRAME_H = 2'd1,
    REG_MIN_SIDE = 2'd2,
    REG_OUT_CAP = 2'd3
  } reg_idx_e;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_INS   = 8'b0000_0010,
    S_MSCAN = 8'b0000_0100,
    S_MFIX  = 8'b0000_1000,
    S_AREA  = 8'b0001_0000,
    S_SORT  = 8'b0010_0000,
    S_EMIT  = 8'b0100_0000,
    S_DRAIN = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] w;
    logic [12:0] h;
  } box_t;

  typedef struct packed {
    box_t        box;
    logic [25:0] area;
  } ent_t;

  function automatic logic near_box(box_t a, box_t b);
    logic [14:0] ar, ab, br, bb;
    ar = 15'(a.x) + 15'(a.w) + 15'(SLACK);
    ab = 15'(a.y) + 15'(a.h) + 15'(SLACK);
    br = 15'(b.x) + 15'(b.w) + 15'(SLACK);
    bb = 15'(b.y) + 15'(b.h) + 15'(SLACK);
    return (15'(a.x) < br) && (15'(b.x) < ar) && (15'(a.y) < bb) && (15'(b.y) < ab);
  endfunction

  function automatic box_t grow_box(box_t d, box_t s);
    logic [13:0] dr, db, sr, sb, r, bt;
    box_t        o;
    dr = 14'(d.x) + 14'(d.w);
    db = 14'(d.y) + 14'(d.h);
    sr = 14'(s.x) + 14'(s.w);
    sb = 14'(s.y) + 14'(s.h);
    r  = (dr > sr) ? dr : sr;
    bt = (db > sb) ? db : sb;
    o.x = (s.x < d.x) ? s.x : d.x;
    o.y = (s.y < d.y) ? s.y : d.y;
    o.w = 13'(r - 14'(o.x));
    o.h = 13'(bt - 14'(o.y));
    return o;
  endfunction

endpackage

/* hdl/mbm_cell.sv */
`timescale 1ns / 1ps
// mbm_cell: one slot of the box row; rotates towards the head or takes part
// in an odd-even transposition step. Depends on mbm_pkg.
module mbm_cell import mbm_pkg::*; (
  input  logic clk_i,
  input  logic rot_i,
  input  logic sort_i,
  input  logic act_i,
  input  logic swl_i,
  input  ent_t nxt_i,
  input  ent_t prv_i,
  output ent_t ent_o,
  output logic swr_o
);

  ent_t ent_q, ent_d;

  assign swr_o = sort_i && act_i && (ent_q.area < nxt_i.area);
  assign ent_o = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (rot_i || swr_o) begin
      ent_d = nxt_i;
    end else if (sort_i && swl_i) begin
      ent_d = prv_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

/* hdl/mbm_square.sv */
`timescale 1ns / 1ps
// mbm_square: four-stage pipeline from a box to its crop square, with the
// result registers. Depends on mbm_pkg.
module mbm_square import mbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        v_i,
  input  box_t        box_i,
  input  logic        last_i,
  input  logic        nr_i,
  input  logic [4:0]  drop_i,
  input  logic [12:0] fw_i,
  input  logic [12:0] fh_i,
  input  logic [12:0] minv_i,
  output logic        valid_o,
  output logic [11:0] square_x_o,
  output logic [11:0] square_y_o,
  output logic [12:0] square_side_o,
  output logic [4:0]  dropped_count_o,
  output logic        no_region_o,
  output logic        last_square_o,
  output logic        busy_o
);

  logic [3:0]  v_q;
  logic [2:0]  last_q, nr_q;
  logic [4:0]  drop_q [3];
  logic [15:0] t1_q;
  logic [13:0] cx_q [2], cy_q [2];
  logic [13:0] cx3_q, cy3_q;
  logic [13:0] q2_q;
  logic [12:0] side3_q;
  logic [12:0] mx;
  logic [31:0] prod;
  logic [13:0] s14a, s14b, s14c;
  logic [11:0] half;
  logic signed [14:0] px_s, py_s;
  logic [13:0] px, py;
  logic [11:0] sx_d, sy_d;

  assign mx   = (box_i.w > box_i.h) ? box_i.w : box_i.h;
  assign prod = t1_q * RECIP5;

  always_comb begin
    s14a = (q2_q < 14'(minv_i)) ? 14'(minv_i) : q2_q;
    s14b = (s14a > 14'(fw_i)) ? 14'(fw_i) : s14a;
    s14c = (s14b > 14'(fh_i)) ? 14'(fh_i) : s14b;
  end

  always_comb begin
    half = side3_q[12:1];
    px_s = $signed({1'b0, cx3_q}) - $signed({3'b000, half});
    py_s = $signed({1'b0, cy3_q}) - $signed({3'b000, half});
    px = px_s[14] ? 14'd0 : px_s[13:0];
    py = py_s[14] ? 14'd0 : py_s[13:0];
    sx_d = ((15'(px) + 15'(side3_q)) > 15'(fw_i)) ? 12'(fw_i - side3_q) : px[11:0];
    sy_d = ((15'(py) + 15'(side3_q)) > 15'(fh_i)) ? 12'(fh_i - side3_q) : py[11:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      valid_o <= 1'b0;
    end else begin
      v_q     <= {v_q[2:0], v_i};
      valid_o <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    last_q  <= {last_q[1:0], last_i};
    nr_q    <= {nr_q[1:0], nr_i};
    drop_q[0] <= drop_i;
    drop_q[1] <= drop_q[0];
    drop_q[2] <= drop_q[1];
    t1_q    <= {1'b0, mx, 2'b00} + {2'b00, mx, 1'b0};
    cx_q[0] <= 14'(box_i.x) + 14'(box_i.w[12:1]);
    cy_q[0] <= 14'(box_i.y) + 14'(box_i.h[12:1]);
    q2_q    <= prod[31:18];
    cx_q[1] <= cx_q[0];
    cy_q[1] <= cy_q[0];
    side3_q <= s14c[12:0];
    cx3_q   <= cx_q[1];
    cy3_q   <= cy_q[1];
    if (nr_q[2]) begin
      square_x_o    <= '0;
      square_y_o    <= '0;
      square_side_o <= '0;
      dropped_count_o <= '0;
      no_region_o   <= 1'b1;
      last_square_o <= 1'b1;
    end else begin
      square_x_o    <= sx_d;
      square_y_o    <= sy_d;
      square_side_o <= side3_q;
      dropped_count_o <= last_q[2] ? drop_q[2] : 5'd0;
      no_region_o   <= 1'b0;
      last_square_o <= last_q[2];
    end
  end

  assign busy_o = |v_q;

endmodule

/* hdl/motion_box_merge_square_crop.sv */
`timescale 1ns / 1ps
// motion_box_merge_square_crop: top level; FSM, APB registers, box row of
// mbm_cell and the mbm_square pipeline. Depends on mbm_pkg, mbm_cell, mbm_square.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+-------------------------------
//  rect in   | start high, busy low         | rect_x/y/w/h_i, last_rect_i
//  square out| result_valid_o, one cycle    | square_*_o, dropped_count_o, ...
//  config    | APB write, pready tied high  | pwdata at 4*index
//
// A rectangle holds busy for one full turn of the box row past the head
// comparator, so the block takes no new rectangle until that turn is done;
// a zero-size one that is not last leaves busy low. The last one then
// adds merge turns (two row turns per merged pair, one per head box tried),
// one area turn, STORE_DEPTH sort steps, the emission of the squares and the
// drain of the square pipeline. Reset empties the store; no clearing pass.
// The receiver cannot stall results.
module motion_box_merge_square_crop import mbm_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] rect_x_i,
  input  logic [11:0] rect_y_i,
  input  logic [12:0] rect_w_i,
  input  logic [12:0] rect_h_i,
  input  logic        last_rect_i,
  output logic        result_valid_o,
  output logic [11:0] square_x_o,
  output logic [11:0] square_y_o,
  output logic [12:0] square_side_o,
  output logic [4:0]  dropped_count_o,
  output logic        no_region_o,
  output logic        last_square_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned N  = STORE_DEPTH;
  localparam int unsigned SW = $clog2(N);
  localparam int unsigned CW = $clog2(N + 1);
  localparam int unsigned EW = (CW > 6) ? CW : 6;

  // configuration
  logic [12:0] fw_q, fh_q, mins_q;
  logic [5:0]  cap_q;
  logic [12:0] fw_c, fh_c, minv;
  logic [5:0]  cap_c;
  logic        wr_en;
  reg_idx_e    ridx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign ridx   = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= 13'd1920;
      fh_q   <= 13'd1080;
      mins_q <= 13'd0;
      cap_q  <= 6'd32;
    end else if (wr_en) begin
      case (ridx)
        REG_FRAME_W:  fw_q   <= pwdata[12:0];
        REG_FRAME_H:  fh_q   <= pwdata[12:0];
        REG_MIN_SIDE: mins_q <= pwdata[12:0];
        REG_OUT_CAP:  cap_q  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_FRAME_W:  prdata = 32'(fw_q);
      REG_FRAME_H:  prdata = 32'(fh_q);
      REG_MIN_SIDE: prdata = 32'(mins_q);
      REG_OUT_CAP:  prdata = 32'(cap_q);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    fw_c  = (fw_q == 13'd0) ? 13'd1 : ((fw_q > 13'(FRAME_MAX)) ? 13'(FRAME_MAX) : fw_q);
    fh_c  = (fh_q == 13'd0) ? 13'd1 : ((fh_q > 13'(FRAME_MAX)) ? 13'(FRAME_MAX) : fh_q);
    minv  = (mins_q == 13'd0) ? 13'(DEF_SIDE) : mins_q;
    cap_c = (cap_q == 6'd0) ? 6'd1 : ((cap_q > 6'(MAX_CAP)) ? 6'(MAX_CAP) : cap_q);
  end

  // control
  state_e         state_q, state_d;
  logic [SW-1:0]  step_q, step_d, mi_q, mi_d, jf_q, jf_d;
  logic [CW-1:0]  n_q, n_d, stepc;
  logic           found_q, found_d, merged_q, merged_d, last_q, last_d;
  box_t           cand_q, cand_d, hold_q, hold_d, jbox_q, jbox_d, lbox_q, lbox_d;
  logic           step_end, acc, rot, sort_en;
  ent_t           head, tail_in;
  logic           sq_v, sq_last, sq_nr, sq_busy;
  logic [EW-1:0]  emit, drop_w;
  logic [4:0]     drop5;
  box_t           in_box;

  ent_t           cell_q [N];
  logic [N-1:0]   swr;

  assign head     = cell_q[0];
  assign stepc    = CW'(step_q);
  assign step_end = (step_q == SW'(N - 1));
  assign acc      = start && !busy;
  assign busy     = (state_q != S_IDLE);

  always_comb begin
    in_box.x = rect_x_i;
    in_box.y = rect_y_i;
    in_box.w = (rect_w_i > 13'(FRAME_MAX)) ? 13'(FRAME_MAX) : rect_w_i;
    in_box.h = (rect_h_i > 13'(FRAME_MAX)) ? 13'(FRAME_MAX) : rect_h_i;
  end

  always_comb begin
    emit   = (EW'(n_q) < EW'(cap_c)) ? EW'(n_q) : EW'(cap_c);
    drop_w = EW'(n_q) - emit;
    drop5  = (drop_w > EW'(31)) ? 5'd31 : drop_w[4:0];
  end

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    n_d      = n_q;
    mi_d     = mi_q;
    jf_d     = jf_q;
    found_d  = found_q;
    merged_d = merged_q;
    last_d   = last_q;
    cand_d   = cand_q;
    hold_d   = hold_q;
    jbox_d   = jbox_q;
    lbox_d   = lbox_q;
    tail_in  = head;
    rot      = 1'b0;
    sort_en  = 1'b0;
    sq_v     = 1'b0;
    sq_last  = 1'b0;
    sq_nr    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          cand_d = in_box;
          last_d = last_rect_i;
          step_d = '0;
          mi_d   = '0;
          found_d = 1'b0;
          if (in_box.w != 13'd0 && in_box.h != 13'd0) begin
            merged_d = 1'b0;
            state_d  = S_INS;
          end else if (last_rect_i) begin
            state_d = (n_q <= CW'(1)) ? S_AREA : S_MSCAN;
          end
        end
      end
      S_INS: begin
        rot    = 1'b1;
        step_d = step_q + 1'b1;
        if (!merged_q && stepc < n_q && near_box(head.box, cand_q)) begin
          tail_in.box = grow_box(head.box, cand_q);
          merged_d    = 1'b1;
        end else if (!merged_q && stepc == n_q && n_q < CW'(N)) begin
          tail_in.box = cand_q;
          merged_d    = 1'b1;
          n_d         = n_q + 1'b1;
        end
        if (step_end) begin
          step_d = '0;
          if (!last_q) begin
            state_d = S_IDLE;
          end else begin
            state_d = (n_d <= CW'(1)) ? S_AREA : S_MSCAN;
          end
        end
      end
      S_MSCAN: begin
        rot    = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == mi_q) begin
          hold_d = head.box;
        end
        if (step_q > mi_q && stepc < n_q && !found_q && near_box(hold_q, head.box)) begin
          found_d = 1'b1;
          jf_d    = step_q;
          jbox_d  = head.box;
        end
        if (stepc == n_q - 1'b1) begin
          lbox_d = head.box;
        end
        if (step_end) begin
          step_d = '0;
          if (found_d) begin
            state_d = S_MFIX;
          end else if (CW'(mi_q) + CW'(2) >= n_q) begin
            state_d = S_AREA;
          end else begin
            mi_d = mi_q + 1'b1;
          end
        end
      end
      S_MFIX: begin
        rot    = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == mi_q) begin
          tail_in.box = grow_box(hold_q, jbox_q);
        end else if (step_q == jf_q) begin
          tail_in.box = lbox_q;
        end
        if (step_end) begin
          step_d  = '0;
          n_d     = n_q - 1'b1;
          mi_d    = '0;
          found_d = 1'b0;
          state_d = (n_d <= CW'(1)) ? S_AREA : S_MSCAN;
        end
      end
      S_AREA: begin
        rot          = 1'b1;
        step_d       = step_q + 1'b1;
        tail_in.area = head.box.w * head.box.h;
        if (step_end) begin
          step_d  = '0;
          state_d = S_SORT;
        end
      end
      S_SORT: begin
        sort_en = 1'b1;
        step_d  = step_q + 1'b1;
        if (step_end) begin
          step_d = '0;
          if (n_q == '0) begin
            sq_v    = 1'b1;
            sq_nr   = 1'b1;
            state_d = S_DRAIN;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        rot     = 1'b1;
        step_d  = step_q + 1'b1;
        sq_v    = 1'b1;
        sq_last = (EW'(step_q) + EW'(1) == emit);
        if (sq_last) begin
          step_d  = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sq_busy) begin
          n_d     = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= '0;
      n_q      <= '0;
      mi_q     <= '0;
      jf_q     <= '0;
      found_q  <= 1'b0;
      merged_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      n_q      <= n_d;
      mi_q     <= mi_d;
      jf_q     <= jf_d;
      found_q  <= found_d;
      merged_q <= merged_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    hold_q <= hold_d;
    jbox_q <= jbox_d;
    lbox_q <= lbox_d;
  end

  // box row
  for (genvar k = 0; k < N; k++) begin : g_cell
    ent_t nxt, prv;
    logic swl, act;
    if (k == N - 1) begin : g_tail
      assign nxt = tail_in;
    end else begin : g_mid
      assign nxt = cell_q[k+1];
    end
    if (k == 0) begin : g_head
      assign prv = cell_q[N-1];
      assign swl = 1'b0;
    end else begin : g_body
      assign prv = cell_q[k-1];
      assign swl = swr[k-1];
    end
    assign act = ((k % 2) == int'(step_q[0])) && (CW'(k + 1) < n_q);

    mbm_cell u_cell (
      .clk_i  (clk_i),
      .rot_i  (rot),
      .sort_i (sort_en),
      .act_i  (act),
      .swl_i  (swl),
      .nxt_i  (nxt),
      .prv_i  (prv),
      .ent_o  (cell_q[k]),
      .swr_o  (swr[k])
    );
  end

  mbm_square u_square (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .v_i             (sq_v),
    .box_i           (head.box),
    .last_i          (sq_last),
    .nr_i            (sq_nr),
    .drop_i          (drop5),
    .fw_i            (fw_c),
    .fh_i            (fh_c),
    .minv_i          (minv),
    .valid_o         (result_valid_o),
    .square_x_o      (square_x_o),
    .square_y_o      (square_y_o),
    .square_side_o   (square_side_o),
    .dropped_count_o (dropped_count_o),
    .no_region_o     (no_region_o),
    .last_square_o   (last_square_o),
    .busy_o          (sq_busy)
  );

endmodule

/* tb/mbm_checker.sv */
`timescale 1ns / 1ps
// mbm_checker: watches the rectangle, square and APB channels of
// motion_box_merge_square_crop, predicts the crop squares and compares them.
// Depends on mbm_pkg for the register indexes.
module mbm_checker import mbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [11:0] rect_x_i,
  input  logic [11:0] rect_y_i,
  input  logic [12:0] rect_w_i,
  input  logic [12:0] rect_h_i,
  input  logic        last_rect_i,
  input  logic        result_valid_o,
  input  logic [11:0] square_x_o,
  input  logic [11:0] square_y_o,
  input  logic [12:0] square_side_o,
  input  logic [4:0]  dropped_count_o,
  input  logic        no_region_o,
  input  logic        last_square_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    int x;
    int y;
    int w;
    int h;
  } geo_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] side;
    logic [4:0]  drop;
    logic        none;
    logic        last;
  } square_t;

  localparam int DEPTH = 32;

  geo_t        boxes[DEPTH];
  int          n_boxes;
  int          cfg_fw, cfg_fh, cfg_min, cfg_cap;
  square_t     square_q[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = square_q.size();

  function automatic bit touches(geo_t a, geo_t b);
    return a.x - 16 < b.x + b.w && b.x - 16 < a.x + a.w &&
           a.y - 16 < b.y + b.h && b.y - 16 < a.y + a.h;
  endfunction

  function automatic geo_t union_of(geo_t d, geo_t s);
    int   r, bt;
    geo_t o;
    r  = (d.x + d.w > s.x + s.w) ? d.x + d.w : s.x + s.w;
    bt = (d.y + d.h > s.y + s.h) ? d.y + d.h : s.y + s.h;
    o.x = (s.x < d.x) ? s.x : d.x;
    o.y = (s.y < d.y) ? s.y : d.y;
    o.w = r - o.x;
    o.h = bt - o.y;
    return o;
  endfunction

  function automatic int frame_dim(int v);
    if (v == 0) return 1;
    if (v > 4096) return 4096;
    return v;
  endfunction

  task automatic crop_squares();
    int      n, fw, fh, minv, cap, emit, drop, side, px, py, j;
    bit      again;
    geo_t    t;
    longint  at;
    square_t sq;
    n    = n_boxes;
    fw   = frame_dim(cfg_fw);
    fh   = frame_dim(cfg_fh);
    minv = (cfg_min == 0) ? 320 : cfg_min;
    cap  = (cfg_cap == 0) ? 1 : (cfg_cap > 32 ? 32 : cfg_cap);
    again = 1;
    while (again) begin
      again = 0;
      for (int i = 0; i < n && !again; i++) begin
        for (int k = i + 1; k < n; k++) begin
          if (touches(boxes[i], boxes[k])) begin
            boxes[i] = union_of(boxes[i], boxes[k]);
            boxes[k] = boxes[n - 1];
            n--;
            again = 1;
            break;
          end
        end
      end
    end
    for (int i = 1; i < n; i++) begin
      t  = boxes[i];
      at = longint'(t.w) * t.h;
      j  = i;
      while (j > 0 && longint'(boxes[j - 1].w) * boxes[j - 1].h < at) begin
        boxes[j] = boxes[j - 1];
        j--;
      end
      boxes[j] = t;
    end
    n_boxes = 0;
    if (n == 0) begin
      sq = '0;
      sq.none = 1'b1;
      sq.last = 1'b1;
      square_q.push_back(sq);
      return;
    end
    emit = (n < cap) ? n : cap;
    drop = n - emit;
    if (drop > 31) drop = 31;
    for (int i = 0; i < emit; i++) begin
      side = ((boxes[i].w > boxes[i].h) ? boxes[i].w : boxes[i].h) * 6 / 5;
      if (side < minv) side = minv;
      if (side > fw) side = fw;
      if (side > fh) side = fh;
      px = boxes[i].x + boxes[i].w / 2 - side / 2;
      py = boxes[i].y + boxes[i].h / 2 - side / 2;
      if (px < 0) px = 0;
      if (py < 0) py = 0;
      if (px + side > fw) px = fw - side;
      if (py + side > fh) py = fh - side;
      sq.x    = 12'(px);
      sq.y    = 12'(py);
      sq.side = 13'(side);
      sq.drop = (i + 1 == emit) ? 5'(drop) : 5'd0;
      sq.none = 1'b0;
      sq.last = (i + 1 == emit);
      square_q.push_back(sq);
    end
  endtask

  task automatic take_rect();
    geo_t c;
    bit   merged;
    c.x = rect_x_i;
    c.y = rect_y_i;
    c.w = (rect_w_i > 13'd4096) ? 4096 : int'(rect_w_i);
    c.h = (rect_h_i > 13'd4096) ? 4096 : int'(rect_h_i);
    if (c.w != 0 && c.h != 0) begin
      merged = 0;
      for (int k = 0; k < n_boxes; k++) begin
        if (touches(boxes[k], c)) begin
          boxes[k] = union_of(boxes[k], c);
          merged = 1;
          break;
        end
      end
      if (!merged && n_boxes < DEPTH) begin
        boxes[n_boxes] = c;
        n_boxes++;
      end
    end
    if (last_rect_i) crop_squares();
  endtask

  always @(posedge clk_i) begin
    square_t got, want;
    if (!rst_ni) begin
      n_boxes = 0;
      cfg_fw  = 1920;
      cfg_fh  = 1080;
      cfg_min = 0;
      cfg_cap = 32;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_FRAME_W:  cfg_fw  = pwdata[12:0];
          REG_FRAME_H:  cfg_fh  = pwdata[12:0];
          REG_MIN_SIDE: cfg_min = pwdata[12:0];
          REG_OUT_CAP:  cfg_cap = pwdata[5:0];
          default: ;
        endcase
      end
      if (result_valid_o) begin
        got = '{square_x_o, square_y_o, square_side_o, dropped_count_o,
                no_region_o, last_square_o};
        if (square_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected square transfer: %p", got);
        end else begin
          want = square_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10) $display("square mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (start && !busy) take_rect();
    end
  end

  initial fails = 0;

endmodule

/* tb/motion_box_merge_square_crop_tb.sv */
`timescale 1ns / 1ps
// motion_box_merge_square_crop_tb: drives rectangle lists and register writes
// into the block and gives the verdict. Depends on mbm_pkg, the block and mbm_checker.
module motion_box_merge_square_crop_tb import mbm_pkg::*;;

  logic        clk_i, rst_ni, start, busy;
  logic [11:0] rect_x_i, rect_y_i;
  logic [12:0] rect_w_i, rect_h_i;
  logic        last_rect_i;
  logic        result_valid_o;
  logic [11:0] square_x_o, square_y_o;
  logic [12:0] square_side_o;
  logic [4:0]  dropped_count_o;
  logic        no_region_o, last_square_o;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending;
  int          n_sent;

  motion_box_merge_square_crop u_dut (.*);

  mbm_checker u_chk (
    .clk_i, .rst_ni, .start, .busy, .rect_x_i, .rect_y_i, .rect_w_i, .rect_h_i,
    .last_rect_i, .result_valid_o, .square_x_o, .square_y_o, .square_side_o,
    .dropped_count_o, .no_region_o, .last_square_o, .psel, .penable, .pwrite,
    .paddr, .pwdata, .pready, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_rect(int x, int y, int w, int h, bit last);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    rect_x_i    <= 12'(x);
    rect_y_i    <= 12'(y);
    rect_w_i    <= 13'(w);
    rect_h_i    <= 13'(h);
    last_rect_i <= last;
    do @(posedge clk_i); while (busy);
    n_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_frame(logic [31:0] fw, logic [31:0] fh, logic [31:0] ms,
                           logic [31:0] cap);
    settle();
    write_reg(REG_FRAME_W, fw);
    write_reg(REG_FRAME_H, fh);
    write_reg(REG_MIN_SIDE, ms);
    write_reg(REG_OUT_CAP, cap);
  endtask

  task automatic random_list(int len);
    int cx, cy, spread, w, h, sel;
    cx = $urandom_range(0, 4095);
    cy = $urandom_range(0, 4095);
    spread = ($urandom_range(0, 1) != 0) ? 300 : 4095;
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(0, 19);
      w = $urandom_range(1, 300);
      h = $urandom_range(1, 300);
      if (sel == 0) w = 0;
      else if (sel == 1) h = 0;
      else if (sel == 2) w = $urandom_range(0, 8191);
      else if (sel == 3) h = $urandom_range(0, 8191);
      send_rect((cx + $urandom_range(0, spread)) % 4096,
                (cy + $urandom_range(0, spread)) % 4096, w, h, i == len - 1);
    end
  endtask

  initial begin
    logic [31:0] fw, fh, ms, cap;
    n_sent = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    rect_x_i = '0;
    rect_y_i = '0;
    rect_w_i = '0;
    rect_h_i = '0;
    last_rect_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: empty list, skipped last, extremes, oversized sizes
    send_rect(0, 0, 0, 5, 1);
    send_rect(0, 0, 4096, 4096, 1);
    send_rect(4095, 4095, 1, 1, 0);
    send_rect(4090, 4090, 8191, 8191, 0);
    send_rect(10, 10, 20, 20, 0);
    send_rect(40, 40, 5, 5, 0);
    send_rect(2000, 900, 50, 60, 0);
    send_rect(100, 100, 7, 0, 1);

    // capacity one, store overflow, big minimum side
    set_frame(4096, 4096, 4096, 1);
    for (int i = 0; i < 33; i++)
      send_rect((i % 8) * 500, (i / 8) * 500, 10 + i, 10, i == 32);

    // out-of-range register values
    set_frame(0, 8191, 1, 0);
    send_rect(3, 3, 3, 3, 1);
    set_frame(5000, 1, 0, 63);
    send_rect(4095, 0, 100, 100, 0);
    send_rect(0, 4095, 4096, 1, 1);

    while (n_sent < 370) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0: fw = $urandom_range(1, 4096);
          1: fw = 4096;
          2: fw = 1;
          default: fw = $urandom;
        endcase
        fh  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(200, 4096);
        ms  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8191) | ($urandom << 13);
        cap = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(1, 32);
        set_frame(fw, fh, ms, cap);
      end
      random_list(($urandom_range(0, 9) == 0) ? $urandom_range(30, 45)
                                               : $urandom_range(1, 12));
    end

    settle();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
